// File: rtl/aoop_pkg.sv
// Shared types, constants and lookup functions for the axis-order option parser.
package aoop_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PAIR  = 2'd1;
  localparam logic [1:0] ST_KEY   = 2'd2;
  localparam logic [1:0] ST_VALUE = 2'd3;

  // Axis order codes
  localparam logic [1:0] ORD_LONG_LAT = 2'd0;
  localparam logic [1:0] ORD_LAT_LONG = 2'd1;
  localparam logic [1:0] ORD_SRID     = 2'd2;

  localparam int unsigned NumCand = 3;

  localparam logic [3:0] KEY_LEN = 4'd10;
  localparam logic [3:0] POS_MAX = 4'd15;

  // Character codes
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Per-byte classification and match flags, from the classifier to the parser
  typedef struct packed {
    logic               ws;
    logic               word;
    logic               eq;
    logic               key_ok;
    logic [NumCand-1:0] cand_ok;
  } cls_t;

  // Fold upper-case letters to lower case
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // Text of the key "axis-order"
  function automatic logic [7:0] key_byte(input logic [3:0] p);
    logic [7:0] b;
    case (p)
      4'd0:    b = "a";
      4'd1:    b = "x";
      4'd2:    b = "i";
      4'd3:    b = "s";
      4'd4:    b = "-";
      4'd5:    b = "o";
      4'd6:    b = "r";
      4'd7:    b = "d";
      4'd8:    b = "e";
      4'd9:    b = "r";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Length of each value candidate
  function automatic logic [3:0] cand_len(input logic [1:0] k);
    logic [3:0] n;
    case (k)
      2'd0:    n = 4'd8;
      2'd1:    n = 4'd8;
      default: n = 4'd12;
    endcase
    return n;
  endfunction

  // Text of the value candidates: long-lat, lat-long, srid-defined
  function automatic logic [7:0] cand_byte(input logic [1:0] k, input logic [3:0] p);
    logic [7:0] b;
    b = 8'h00;
    case (k)
      2'd0: begin
        case (p)
          4'd0:    b = "l";
          4'd1:    b = "o";
          4'd2:    b = "n";
          4'd3:    b = "g";
          4'd4:    b = "-";
          4'd5:    b = "l";
          4'd6:    b = "a";
          4'd7:    b = "t";
          default: b = 8'h00;
        endcase
      end
      2'd1: begin
        case (p)
          4'd0:    b = "l";
          4'd1:    b = "a";
          4'd2:    b = "t";
          4'd3:    b = "-";
          4'd4:    b = "l";
          4'd5:    b = "o";
          4'd6:    b = "n";
          4'd7:    b = "g";
          default: b = 8'h00;
        endcase
      end
      default: begin
        case (p)
          4'd0:    b = "s";
          4'd1:    b = "r";
          4'd2:    b = "i";
          4'd3:    b = "d";
          4'd4:    b = "-";
          4'd5:    b = "d";
          4'd6:    b = "e";
          4'd7:    b = "f";
          4'd8:    b = "i";
          4'd9:    b = "n";
          4'd10:   b = "e";
          4'd11:   b = "d";
          default: b = 8'h00;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// File: rtl/aoop_classify.sv
// Byte classifier: whitespace, word and '=' tests plus key and candidate matches.
module aoop_classify import aoop_pkg::*; (
  input  logic [7:0] char_code_i,
  input  logic [3:0] key_pos_i,
  input  logic [3:0] val_len_i,
  output cls_t       cls_o
);

  logic [7:0] folded;

  assign folded = fold_char(char_code_i);

  // Classify the byte and compare it against the expected key and value letters
  always_comb begin
    cls_o.ws     = (char_code_i >= 8'd9 && char_code_i <= 8'd13) || (char_code_i == CH_SPACE);
    cls_o.word   = (folded >= 8'h61 && folded <= 8'h7A) || (char_code_i == CH_DASH);
    cls_o.eq     = (char_code_i == CH_EQ);
    cls_o.key_ok = (key_pos_i < KEY_LEN) && (folded == key_byte(key_pos_i));
    for (int k = 0; k < NumCand; k++) begin
      cls_o.cand_ok[k] = (val_len_i < cand_len(2'(k))) &&
                         (folded == cand_byte(2'(k), val_len_i));
    end
  end

endmodule

// File: rtl/aoop_parse.sv
// Parse state machine: phase, key and value match tracking, end-of-string result.
module aoop_parse import aoop_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       last_char_i,
  input  logic       empty_string_i,
  input  cls_t       cls_i,
  output logic [3:0] key_pos_o,
  output logic [3:0] val_len_o,
  output logic       res_valid_o,
  output logic [1:0] res_status_o,
  output logic [1:0] res_order_o
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_KEY, PH_PREEQ, PH_POSTEQ, PH_VALUE, PH_TAIL, PH_ERR
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [3:0]         key_pos_q, key_pos_d;
  logic               key_mm_q, key_mm_d;
  logic [3:0]         val_len_q, val_len_d;
  logic [NumCand-1:0] cand_q, cand_d;
  logic [1:0]         err_q, err_d;
  logic               str_end;

  assign key_pos_o   = key_pos_q;
  assign val_len_o   = val_len_q;
  assign str_end     = empty_string_i || last_char_i;
  assign res_valid_o = str_end;

  // Advance the parse with the current byte
  always_comb begin
    phase_d   = phase_q;
    key_pos_d = key_pos_q;
    key_mm_d  = key_mm_q;
    val_len_d = val_len_q;
    cand_d    = cand_q;
    err_d     = err_q;
    if (!empty_string_i) begin
      case (phase_q)
        PH_LEAD: begin
          if (cls_i.ws) begin
            phase_d = PH_LEAD;
          end else if (cls_i.word) begin
            phase_d = PH_KEY;
            if (!cls_i.key_ok) key_mm_d = 1'b1;
            if (key_pos_q != POS_MAX) key_pos_d = key_pos_q + 4'd1;
          end else begin
            phase_d = PH_ERR;
            err_d   = ST_PAIR;
          end
        end
        PH_KEY: begin
          if (cls_i.word) begin
            if (!cls_i.key_ok) key_mm_d = 1'b1;
            if (key_pos_q != POS_MAX) key_pos_d = key_pos_q + 4'd1;
          end else if (key_mm_q || key_pos_q != KEY_LEN) begin
            phase_d = PH_ERR;
            err_d   = ST_KEY;
          end else if (cls_i.ws) begin
            phase_d = PH_PREEQ;
          end else if (cls_i.eq) begin
            phase_d = PH_POSTEQ;
          end else begin
            phase_d = PH_ERR;
            err_d   = ST_PAIR;
          end
        end
        PH_PREEQ: begin
          if (cls_i.eq) begin
            phase_d = PH_POSTEQ;
          end else if (!cls_i.ws) begin
            phase_d = PH_ERR;
            err_d   = ST_PAIR;
          end
        end
        PH_POSTEQ: begin
          if (cls_i.ws) begin
            phase_d = PH_POSTEQ;
          end else if (cls_i.word) begin
            phase_d = PH_VALUE;
            cand_d  = cand_q & cls_i.cand_ok;
            if (val_len_q != POS_MAX) val_len_d = val_len_q + 4'd1;
          end else begin
            phase_d = PH_ERR;
            err_d   = ST_PAIR;
          end
        end
        PH_VALUE: begin
          if (cls_i.word) begin
            cand_d = cand_q & cls_i.cand_ok;
            if (val_len_q != POS_MAX) val_len_d = val_len_q + 4'd1;
          end else if (cls_i.ws) begin
            phase_d = PH_TAIL;
          end else begin
            phase_d = PH_ERR;
            err_d   = ST_VALUE;
          end
        end
        PH_TAIL: begin
          if (!cls_i.ws) begin
            phase_d = PH_ERR;
            err_d   = ST_VALUE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Form the result from the state after this byte
  always_comb begin
    res_status_o = ST_OK;
    res_order_o  = ORD_LONG_LAT;
    case (phase_d)
      PH_LEAD: begin
        res_order_o = ORD_SRID;
      end
      PH_KEY, PH_PREEQ, PH_POSTEQ: begin
        res_status_o = ST_PAIR;
      end
      PH_VALUE, PH_TAIL: begin
        if (cand_d[0] && val_len_d == cand_len(2'd0)) begin
          res_order_o = ORD_LONG_LAT;
        end else if (cand_d[1] && val_len_d == cand_len(2'd1)) begin
          res_order_o = ORD_LAT_LONG;
        end else if (cand_d[2] && val_len_d == cand_len(2'd2)) begin
          res_order_o = ORD_SRID;
        end else begin
          res_status_o = ST_VALUE;
        end
      end
      default: begin
        res_status_o = (err_d == ST_OK) ? ST_PAIR : err_d;
      end
    endcase
  end

  // Hold parse state; return to the start state when a string ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEAD;
      key_pos_q <= '0;
      key_mm_q  <= 1'b0;
      val_len_q <= '0;
      cand_q    <= '1;
      err_q     <= ST_OK;
    end else if (adv_i) begin
      if (str_end) begin
        phase_q   <= PH_LEAD;
        key_pos_q <= '0;
        key_mm_q  <= 1'b0;
        val_len_q <= '0;
        cand_q    <= '1;
        err_q     <= ST_OK;
      end else begin
        phase_q   <= phase_d;
        key_pos_q <= key_pos_d;
        key_mm_q  <= key_mm_d;
        val_len_q <= val_len_d;
        cand_q    <= cand_d;
        err_q     <= err_d;
      end
    end
  end

endmodule

// File: rtl/axis_order_option_parser.sv
// Top level: input register, byte classifier, parse state and result register.
// A result passes through the input register and then the result register before it is valid on the output.
// Throughput: one byte per cycle, unless a string's result waits on a full output register.
// The input register advances unless its item ends a string while a result still waits.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parse
// to the leading-whitespace phase with all value candidates live.
module axis_order_option_parser import aoop_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  input  logic       empty_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [1:0] order_sel_o
);

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_empty_q;
  logic       s1_adv;
  logic       out_free;

  logic       out_valid_q;
  logic [1:0] status_q;
  logic [1:0] order_q;

  cls_t       cls;
  logic [3:0] key_pos;
  logic [3:0] val_len;
  logic       res_valid;
  logic [1:0] res_status;
  logic [1:0] res_order;

  // Advance the held item unless its result would land on a full output register
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!res_valid || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Hold the input item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q  <= char_code_i;
      s1_last_q  <= last_char_i;
      s1_empty_q <= empty_string_i;
    end
  end

  aoop_classify u_classify (
    .char_code_i (s1_char_q),
    .key_pos_i   (key_pos),
    .val_len_i   (val_len),
    .cls_o       (cls)
  );

  aoop_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (s1_adv),
    .last_char_i    (s1_last_q),
    .empty_string_i (s1_empty_q),
    .cls_i          (cls),
    .key_pos_o      (key_pos),
    .val_len_o      (val_len),
    .res_valid_o    (res_valid),
    .res_status_o   (res_status),
    .res_order_o    (res_order)
  );

  // Load a result when a string ends; drop the valid once it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_valid) begin
      status_q <= res_status;
      order_q  <= (res_status == ST_OK) ? res_order : ORD_LONG_LAT;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign order_sel_o = order_q;

endmodule
